// ===== design/refcounted_slot_pool_allocator_defines.svh =====
// Assertion macros for the slot pool allocator.
// They use the clock and reset of the module that they stand in.
`ifndef REFCOUNTED_SLOT_POOL_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_SLOT_POOL_ALLOCATOR_DEFINES_SVH

// expression holds at every edge out of reset
`define RSPA_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("rspa: invariant violated");

// consequence holds in any cycle where the condition holds
`define RSPA_ASSERT_IMPLY(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("rspa: implication violated");

`endif

// ===== design/rspa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rspa_pkg;

   // width of the first-free search window
   localparam int SCAN_BITS     = 16;
   localparam int SCAN_POS_BITS = $clog2(SCAN_BITS);

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;
   localparam logic [1:0] STATUS_UNALLOC = 2'd3;

   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_READY = 2'd1;
   localparam logic [1:0] SLOT_BUSY  = 2'd2;

   typedef struct packed {
      logic       opcode;
      logic [8:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [8:0] granted_slot;
      logic [1:0] slot_state_after;
      logic [7:0] refcount_after;
      logic [3:0] groups_open;
   } rsp_type;

   typedef struct packed {
      logic                     found;
      logic [SCAN_POS_BITS-1:0] pos;
   } find_type;

endpackage

`default_nettype wire

// ===== design/refcounted_slot_pool_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "refcounted_slot_pool_allocator_defines.svh"

// Slot pool allocator with per-slot reference counts. One word in, one word out. An allocate
// reads the occupancy row of each open group in turn from the bitmap memory (a read state and
// a wait state for each group) and searches a non-full row 16 slots a cycle for the first free
// slot; when no open row has a free slot, a new group is opened if the limit allows, else the
// pool is full. A release finds the group by repeated subtraction, one group a cycle, and then
// reads the slot. No new word is taken while one is in progress; a finished word waits in the
// output register, where it does not hold up acceptance of the next request, but that
// request's result is not moved out until the register is free. Rows of unopened groups carry
// valid bits, so there is no clearing pass after reset. csr_wr_data is the group limit; the user
// must see that it is written only while idle, as the block itself does not enforce this.
module refcounted_slot_pool_allocator #(
   parameter int SLOTS_PER_GROUP = 64,
   parameter int MAX_GROUPS      = 8,
   parameter int REF_BITS        = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rspa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rspa_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [3:0]        csr_wr_data
);

   localparam int TOTAL = SLOTS_PER_GROUP * MAX_GROUPS;
   localparam int SW    = $clog2(TOTAL);
   localparam int PW    = $clog2(SLOTS_PER_GROUP);
   localparam int GAW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int GCW   = $clog2(MAX_GROUPS + 1);
   localparam int NCH   = (SLOTS_PER_GROUP + rspa_pkg::SCAN_BITS - 1) / rspa_pkg::SCAN_BITS;
   localparam int CW    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int PAD_W = NCH * rspa_pkg::SCAN_BITS;
   localparam int LIM_W = $clog2(TOTAL + 1);
   localparam int CMP_W = (LIM_W > 9) ? LIM_W : 9;
   localparam int EW    = 2 + REF_BITS;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_A_READ = 7'b0000010,
      ST_A_WAIT = 7'b0000100,
      ST_A_SCAN = 7'b0001000,
      ST_R_DIV  = 7'b0010000,
      ST_R_WAIT = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [3:0]              limit_ff;
   logic [GCW-1:0]          open_ff, open_in;
   logic [MAX_GROUPS-1:0]   row_valid_ff, row_valid_in;
   logic [GCW-1:0]          grp_ff, grp_in;
   logic [CW-1:0]           chunk_ff, chunk_in;
   logic [8:0]              idx_ff, idx_in;
   logic [8:0]              rem_ff, rem_in;
   logic [PAD_W-1:0]        row_ff, row_in;
   rspa_pkg::rsp_type       res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rspa_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   logic                    bm_wr_en;
   logic [GAW-1:0]          bm_addr;
   logic [SLOTS_PER_GROUP-1:0] bm_wr_data, bm_rd_data;
   logic                    sl_wr_en;
   logic [SW-1:0]           sl_wr_addr, sl_rd_addr;
   logic [EW-1:0]           sl_wr_data, sl_rd_data;

   logic [SLOTS_PER_GROUP-1:0] row_eff;
   logic [PAD_W-1:0]        row_pad;
   rspa_pkg::find_type      find_res;
   logic [CW+rspa_pkg::SCAN_POS_BITS-1:0] pos_wide;
   logic [PW-1:0]           pos;
   logic [SW-1:0]           base_slot;
   logic                    can_open;
   logic                    in_range;
   logic [1:0]              ent_state;
   logic [REF_BITS-1:0]     ent_cnt, new_cnt;

   assign bm_addr    = grp_ff[GAW-1:0];
   assign sl_rd_addr = SW'(idx_ff);
   assign row_eff    = row_valid_ff[bm_addr] ? bm_rd_data : '0;
   assign row_pad    = ~PAD_W'(~row_eff);
   assign pos_wide   = {chunk_ff, find_res.pos};
   assign pos        = pos_wide[PW-1:0];
   assign base_slot  = SW'(grp_ff * SLOTS_PER_GROUP);
   assign can_open   = (8'(open_ff) < 8'(limit_ff)) && (open_ff < GCW'(MAX_GROUPS));
   assign in_range   = CMP_W'(req_data.slot_index) < CMP_W'(open_ff * SLOTS_PER_GROUP);
   assign ent_state  = sl_rd_data[EW-1 -: 2];
   assign ent_cnt    = sl_rd_data[REF_BITS-1:0];
   assign new_cnt    = ent_cnt - REF_BITS'(1);

   rspa_find u_find (
      .chunk_bits (row_ff[chunk_ff * rspa_pkg::SCAN_BITS +: rspa_pkg::SCAN_BITS]),
      .result     (find_res)
   );

   rspa_ram #(.WIDTH(SLOTS_PER_GROUP), .DEPTH(MAX_GROUPS)) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_addr),
      .wr_data (bm_wr_data),
      .rd_addr (bm_addr),
      .rd_data (bm_rd_data)
   );

   rspa_ram #(.WIDTH(EW), .DEPTH(TOTAL)) u_slots (
      .clock   (clock),
      .wr_en   (sl_wr_en),
      .wr_addr (sl_wr_addr),
      .wr_data (sl_wr_data),
      .rd_addr (sl_rd_addr),
      .rd_data (sl_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      row_valid_in = row_valid_ff;
      grp_in       = grp_ff;
      chunk_in     = chunk_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      row_in       = row_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      bm_wr_en     = 1'b0;
      bm_wr_data   = row_eff;
      sl_wr_en     = 1'b0;
      sl_wr_addr   = base_slot + SW'(pos);
      sl_wr_data   = {rspa_pkg::SLOT_BUSY, REF_BITS'(1)};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in = req_data.slot_index;
               rem_in = req_data.slot_index;
               grp_in = '0;
               if (req_data.opcode == rspa_pkg::OP_ALLOC) begin
                  state_in = ST_A_READ;
               end else if (in_range) begin
                  state_in = ST_R_DIV;
               end else begin
                  res_in   = '{rspa_pkg::STATUS_RANGE, req_data.slot_index, rspa_pkg::SLOT_EMPTY,
                               8'd0, 4'(open_ff)};
                  state_in = ST_FINISH;
               end
            end
         end
         ST_A_READ: begin
            if (grp_ff == open_ff) begin
               if (can_open) begin
                  open_in               = open_ff + GCW'(1);
                  bm_wr_en              = 1'b1;
                  bm_wr_data            = SLOTS_PER_GROUP'(1);
                  row_valid_in[bm_addr] = 1'b1;
                  sl_wr_en              = 1'b1;
                  sl_wr_addr            = base_slot;
                  res_in = '{rspa_pkg::STATUS_OK, 9'(base_slot), rspa_pkg::SLOT_BUSY,
                             8'd1, 4'(open_in)};
               end else begin
                  res_in = '{rspa_pkg::STATUS_FULL, 9'd0, rspa_pkg::SLOT_EMPTY,
                             8'd0, 4'(open_ff)};
               end
               state_in = ST_FINISH;
            end else begin
               state_in = ST_A_WAIT;
            end
         end
         ST_A_WAIT: begin
            if (&row_pad) begin
               grp_in   = grp_ff + GCW'(1);
               state_in = ST_A_READ;
            end else begin
               row_in   = row_pad;
               chunk_in = '0;
               state_in = ST_A_SCAN;
            end
         end
         ST_A_SCAN: begin
            if (find_res.found) begin
               bm_wr_en              = 1'b1;
               bm_wr_data            = row_ff[SLOTS_PER_GROUP-1:0]
                                       | (SLOTS_PER_GROUP'(1) << pos);
               row_valid_in[bm_addr] = 1'b1;
               sl_wr_en              = 1'b1;
               res_in = '{rspa_pkg::STATUS_OK, 9'(base_slot + SW'(pos)), rspa_pkg::SLOT_BUSY,
                          8'd1, 4'(open_ff)};
               state_in = ST_FINISH;
            end else begin
               chunk_in = chunk_ff + CW'(1);
            end
         end
         ST_R_DIV: begin
            if (rem_ff >= 9'(SLOTS_PER_GROUP)) begin
               rem_in = rem_ff - 9'(SLOTS_PER_GROUP);
               grp_in = grp_ff + GCW'(1);
            end else begin
               state_in = ST_R_WAIT;
            end
         end
         ST_R_WAIT: begin
            sl_wr_addr = SW'(idx_ff);
            if (!row_eff[rem_ff[PW-1:0]] || ent_state == rspa_pkg::SLOT_EMPTY
                || ent_cnt == '0) begin
               res_in = '{rspa_pkg::STATUS_UNALLOC, idx_ff, rspa_pkg::SLOT_EMPTY,
                          8'd0, 4'(open_ff)};
            end else begin
               sl_wr_en = 1'b1;
               if (new_cnt == '0) begin
                  sl_wr_data = {rspa_pkg::SLOT_EMPTY, new_cnt};
                  bm_wr_en   = 1'b1;
                  bm_wr_data = row_eff & ~(SLOTS_PER_GROUP'(1) << rem_ff[PW-1:0]);
                  res_in = '{rspa_pkg::STATUS_OK, idx_ff, rspa_pkg::SLOT_EMPTY,
                             8'd0, 4'(open_ff)};
               end else begin
                  sl_wr_data = {rspa_pkg::SLOT_READY, new_cnt};
                  res_in = '{rspa_pkg::STATUS_OK, idx_ff, rspa_pkg::SLOT_READY,
                             (32'(new_cnt) > 32'd255) ? 8'hFF : 8'(new_cnt), 4'(open_ff)};
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= 4'd8;
         open_ff      <= GCW'(1);
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      chunk_ff    <= chunk_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      row_ff      <= row_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RSPA_ASSERT_ALWAYS(a_open_range, (open_ff != '0) && (open_ff <= GCW'(MAX_GROUPS)))
   `RSPA_ASSERT_ALWAYS(a_rows_only_open, (row_valid_ff >> open_ff) == '0)
   `RSPA_ASSERT_IMPLY(a_scan_open_group, state_ff == ST_A_SCAN, grp_ff < open_ff)
   `RSPA_ASSERT_IMPLY(a_release_in_group, state_ff == ST_R_WAIT, rem_ff < 9'(SLOTS_PER_GROUP))

endmodule

`default_nettype wire

// ===== design/rspa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/rspa_find.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rspa_find (
   input  wire logic [rspa_pkg::SCAN_BITS-1:0] chunk_bits,
   output rspa_pkg::find_type                  result
);

   // lowest clear bit wins
   always_comb begin
      result = '0;
      for (int i = rspa_pkg::SCAN_BITS - 1; i >= 0; i--) begin
         if (!chunk_bits[i]) begin
            result.found = 1'b1;
            result.pos   = i[rspa_pkg::SCAN_POS_BITS-1:0];
         end
      end
   end

endmodule

`default_nettype wire
